[design/bf7_pkg.sv]
// Shared constants, types and the divide-by-49 helper for the 7x7 box filter.
package bf7_pkg;

  localparam int unsigned TAPS    = 7;   // window size in both directions
  localparam int unsigned LINES   = 6;   // line stores, TAPS - 1
  localparam int unsigned HALF    = 3;   // center offset from window edge
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned VSUM_W  = 11;  // 7 * 255 = 1785
  localparam int unsigned HSUM_W  = 14;  // 49 * 255 = 12495
  localparam int unsigned COORD_W = 9;
  localparam int unsigned REG_W   = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [REG_W-1:0] REG_RESET = 10'd512;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // x / 49 == (x * 21400) >> 20 for x < 2^14 (error stays under 1/49)
  localparam int unsigned MUL_W       = 15;
  localparam int unsigned DIV49_SHIFT = 20;
  localparam logic [MUL_W-1:0] DIV49_MUL = 15'd21400;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } coord_t;

  function automatic logic [PIX_W-1:0] div49(input logic [HSUM_W-1:0] s);
    logic [HSUM_W+MUL_W-1:0] p;
    p = (HSUM_W+MUL_W)'(s) * (HSUM_W+MUL_W)'(DIV49_MUL);
    return p[DIV49_SHIFT +: PIX_W];
  endfunction

endpackage

[design/bf7_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module bf7_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/bf7_line_buf.sv]
// Six line stores with same-column forwarding and the vertical 7-tap sum.
module bf7_line_buf #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr_i,
  input  logic [bf7_pkg::PIX_W-1:0]         pix_i,
  output logic [bf7_pkg::VSUM_W-1:0]        vsum_o
);

  logic [bf7_pkg::PIX_W-1:0] rd_data [bf7_pkg::LINES];
  logic [bf7_pkg::PIX_W-1:0] line    [bf7_pkg::LINES];
  logic [bf7_pkg::PIX_W-1:0] wr_data [bf7_pkg::LINES];
  logic [bf7_pkg::PIX_W-1:0] last_q  [bf7_pkg::LINES];
  logic                      fwd_q;

  for (genvar k = 0; k < bf7_pkg::LINES; k++) begin : g_line
    bf7_ram #(
      .WIDTH(bf7_pkg::PIX_W),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en_i),
      .waddr_i(wr_addr_i),
      .wdata_i(wr_data[k]),
      .re_i   (rd_en_i),
      .raddr_i(rd_addr_i),
      .rdata_o(rd_data[k])
    );
  end

  // read raced a write to the same column: take the written column instead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      last_q <= wr_data;
    end
  end

  always_comb begin
    logic [bf7_pkg::VSUM_W-1:0] acc;
    acc = bf7_pkg::VSUM_W'(pix_i);
    for (int k = 0; k < bf7_pkg::LINES; k++) begin
      line[k] = fwd_q ? last_q[k] : rd_data[k];
      acc     = acc + bf7_pkg::VSUM_W'(line[k]);
    end
    // push the column down one line, newest pixel on top
    wr_data[0] = pix_i;
    for (int k = 1; k < bf7_pkg::LINES; k++) begin
      wr_data[k] = line[k-1];
    end
    vsum_o = acc;
  end

endmodule

[design/bf7_window.sv]
// Window of the seven latest column sums and their horizontal total.
module bf7_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [bf7_pkg::VSUM_W-1:0]  vsum_i,
  output logic [bf7_pkg::HSUM_W-1:0]  sum_o
);

  logic [bf7_pkg::VSUM_W-1:0] win_q [bf7_pkg::TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bf7_pkg::TAPS; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_i) begin
      win_q[0] <= vsum_i;
      for (int k = 1; k < bf7_pkg::TAPS; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  always_comb begin
    logic [bf7_pkg::HSUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < bf7_pkg::TAPS; k++) begin
      acc = acc + bf7_pkg::HSUM_W'(win_q[k]);
    end
    sum_o = acc;
  end

endmodule

[design/box_filter_7x7_separable_top.sv]
// Top level of the separable 7x7 mean box filter.
//
// Greyscale pixels stream in raster order, one word per clock, with tuser
// marking the first pixel of a frame (it zeroes the row and column
// counters). Each pixel reads its column from six line stores (block
// RAMs, registered read), forms the vertical 7-tap sum, shifts it into a
// window of seven column sums, totals the window and divides by 49 with
// truncation. Once the pixel at (r,c) arrives with r>=6 and c>=6 a word
// is emitted for center (r-3,c-3); border pixels are never emitted and
// the receiver fills them with zero. The filter takes one pixel every
// clock unless every stage is full and stalled; a result is loaded into
// the output register, from which it can be taken at the next edge.
// The stages are: RAM read, vertical sum and window shift, window total,
// divide into the output register. Each stage holds only while the one
// after it is full and stalled, so bubbles fill and the input keeps
// flowing while a result waits, until every stage behind it is full.
// The line stores need no clearing pass; rows never written are never emitted.
// image_width / image_height (config indexes 0 and 1) saturate to
// [7, MAX_COLS] and [7, MAX_ROWS]; write them only while the filter is idle.
module box_filter_7x7_separable_top #(
  parameter int unsigned MAX_COLS = 512,
  parameter int unsigned MAX_ROWS = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bf7_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bf7_pkg::REG_W-1:0]          cfg_data_i,
  // pixel input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] pixel
  input  logic                               s_axis_tuser,  // [0] frame_start
  // filtered output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [8:0] center_row, [17:9] center_col, [25:18] smoothed_value, [31:26] zero
  output logic [bf7_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned LWC = (CW + 1 > bf7_pkg::REG_W) ? CW + 1 : bf7_pkg::REG_W;
  localparam int unsigned LWR = (RW + 1 > bf7_pkg::REG_W) ? RW + 1 : bf7_pkg::REG_W;
  localparam int unsigned XW0 = (CW > RW) ? CW : RW;
  localparam int unsigned XW  = (XW0 > bf7_pkg::COORD_W) ? XW0 : bf7_pkg::COORD_W;

  // saturate a dimension and return it minus one (last column / row)
  function automatic logic [CW-1:0] col_last(input logic [bf7_pkg::REG_W-1:0] v);
    logic [LWC-1:0] ve;
    ve = LWC'(v);
    if (ve < LWC'(bf7_pkg::TAPS)) return CW'(bf7_pkg::TAPS - 1);
    else if (ve > LWC'(MAX_COLS)) return CW'(MAX_COLS - 1);
    else return CW'(ve - LWC'(1));
  endfunction

  function automatic logic [RW-1:0] row_last(input logic [bf7_pkg::REG_W-1:0] v);
    logic [LWR-1:0] ve;
    ve = LWR'(v);
    if (ve < LWR'(bf7_pkg::TAPS)) return RW'(bf7_pkg::TAPS - 1);
    else if (ve > LWR'(MAX_ROWS)) return RW'(MAX_ROWS - 1);
    else return RW'(ve - LWR'(1));
  endfunction

  // ---------------------------------------------------------------------
  // Config: keep the saturated last column / row, not the raw value
  // ---------------------------------------------------------------------
  logic [CW-1:0] col_last_q;
  logic [RW-1:0] row_last_q;
  logic          cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= col_last(bf7_pkg::REG_RESET);
      row_last_q <= row_last(bf7_pkg::REG_RESET);
    end else if (cfg_we) begin
      if (cfg_index_i == bf7_pkg::CFG_IMAGE_WIDTH) begin
        col_last_q <= col_last(cfg_data_i);
      end
      if (cfg_index_i == bf7_pkg::CFG_IMAGE_HEIGHT) begin
        row_last_q <= row_last(cfg_data_i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Handshake chain: a stage moves when the next one is empty or moving
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;
  logic adv1, adv2, adv3;
  logic accept;

  assign rdyo = !vo_q || m_axis_tready;
  assign adv3 = v3_q && rdyo;
  assign rdy3 = !v3_q || rdyo;
  assign adv2 = v2_q && rdy3;
  assign rdy2 = !v2_q || rdy3;
  assign adv1 = v1_q && rdy2;   // window shift may not overtake stage 2
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Raster counters, updated at accept
  // ---------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic          emit;
  bf7_pkg::coord_t center;

  always_comb begin
    col_cur = s_axis_tuser ? '0 : col_q;
    row_cur = s_axis_tuser ? '0 : row_q;
    if (col_cur >= col_last_q) begin
      col_d = '0;
      row_d = (row_cur >= row_last_q) ? '0 : row_cur + RW'(1);
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end
    emit       = (row_cur >= RW'(bf7_pkg::LINES)) && (col_cur >= CW'(bf7_pkg::LINES));
    center.row = bf7_pkg::COORD_W'(XW'(row_cur) - XW'(bf7_pkg::HALF));
    center.col = bf7_pkg::COORD_W'(XW'(col_cur) - XW'(bf7_pkg::HALF));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line store read in flight, pixel and tag held
  // ---------------------------------------------------------------------
  logic [bf7_pkg::PIX_W-1:0] pix1_q;
  logic [CW-1:0]             col1_q;
  logic                      emit1_q;
  bf7_pkg::coord_t           crd1_q;
  logic [bf7_pkg::VSUM_W-1:0] vsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      emit1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q    <= accept;
      emit1_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q <= s_axis_tdata[bf7_pkg::PIX_W-1:0];
      col1_q <= col_cur;
      crd1_q <= center;
    end
  end

  bf7_line_buf #(
    .DEPTH(MAX_COLS)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(col_cur),
    .wr_en_i  (adv1),
    .wr_addr_i(col1_q),
    .pix_i    (pix1_q),
    .vsum_o   (vsum)
  );

  // ---------------------------------------------------------------------
  // Stage 2: column sum shifted into the window; only emitting pixels
  // occupy the stage
  // ---------------------------------------------------------------------
  bf7_pkg::coord_t            crd2_q;
  logic [bf7_pkg::HSUM_W-1:0] win_sum;

  bf7_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(adv1),
    .vsum_i (vsum),
    .sum_o  (win_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= adv1 && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      crd2_q <= crd1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: 49-pixel total registered
  // ---------------------------------------------------------------------
  logic [bf7_pkg::HSUM_W-1:0] hsum3_q;
  bf7_pkg::coord_t            crd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= adv2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      hsum3_q <= win_sum;
      crd3_q  <= crd2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: divide by 49 via reciprocal multiply
  // ---------------------------------------------------------------------
  logic [bf7_pkg::PIX_W-1:0] val_o_q;
  bf7_pkg::coord_t           crd_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdyo) begin
      vo_q <= adv3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      val_o_q <= bf7_pkg::div49(hsum3_q);
      crd_o_q <= crd3_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {
    {(bf7_pkg::OUT_TDATA_W - 2 * bf7_pkg::COORD_W - bf7_pkg::PIX_W){1'b0}},
    val_o_q,
    crd_o_q.col,
    crd_o_q.row
  };

endmodule

[dv/tb.sv]
// Self-checking testbench for the separable 7x7 box filter: directed frames, then random streams.
module tb;

  localparam int unsigned MAX_COLS      = 512;
  localparam int unsigned MAX_ROWS      = 512;
  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned IDLE_PCT      = 13;
  localparam int unsigned HOLD_CYCLES   = 400;   // long output hold-off
  localparam int unsigned PIPE_SLACK    = 12;    // pipeline is 4 deep, keep margin
  localparam int unsigned RANDOM_PIXELS = 450;
  localparam int unsigned WINDOW_AREA   = bf7_pkg::TAPS * bf7_pkg::TAPS;
  localparam longint      LIMIT_TIME    = 64'd2_000_000;
  localparam int          KEEP          = -1;    // leave the register as it is

  // register slots with no register behind them
  localparam logic [bf7_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [bf7_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum {FILL_ZERO, FILL_FULL, FILL_RAMP, FILL_CHECKER, FILL_RANDOM} fill_e;

  typedef struct packed {
    logic [bf7_pkg::COORD_W-1:0] row;
    logic [bf7_pkg::COORD_W-1:0] col;
    logic [bf7_pkg::PIX_W-1:0]   value;
  } smoothed_t;

  typedef struct {
    int       cfg_w;
    int       cfg_h;
    int       rows;
    fill_e    fill;
    bit       mark;       // frame_start on the first pixel
    bit       pinned;     // smoothed value known up front
    bit [7:0] pin_value;
    bit       spare;      // also poke the unused register slots
  } frame_case_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [bf7_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bf7_pkg::REG_W-1:0]     cfg_data_i;

  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;   // [7:0] pixel
  logic                            s_axis_tuser;   // [0] frame_start
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [bf7_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [8:0] row, [17:9] col, [25:18] value

  always #CLK_HALF clk_i = ~clk_i;

  box_filter_7x7_separable_top #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Filter predictor state
  // ---------------------------------------------------------------------------
  logic [bf7_pkg::PIX_W-1:0]   column_lines [bf7_pkg::LINES][MAX_COLS];  // [0] row above
  logic [bf7_pkg::VSUM_W-1:0]  col_sums [bf7_pkg::TAPS];                 // [0] newest column
  logic [bf7_pkg::COORD_W-1:0] row_cnt;
  logic [bf7_pkg::COORD_W-1:0] col_cnt;
  logic [bf7_pkg::REG_W-1:0]   width_reg;
  logic [bf7_pkg::REG_W-1:0]   height_reg;

  smoothed_t smoothed_due[$];

  bit       pin_active;
  bit [7:0] pin_value;
  bit       steady;            // no idling on either side
  bit       hold_output_req;   // ask the receiver for one long hold-off

  int unsigned pixels_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned cfg_writes;
  int unsigned random_bursts;

  smoothed_t got_word;
  smoothed_t want_word;

  function automatic int unsigned clamp_size(input logic [bf7_pkg::REG_W-1:0] v,
                                             input int unsigned top);
    if (v < bf7_pkg::TAPS) return bf7_pkg::TAPS;
    if (v > top) return top;
    return v;
  endfunction

  // One pixel through the filter: vertical sum, window shift, total / 49.
  task automatic smooth_pixel(input logic [bf7_pkg::PIX_W-1:0] pix, input logic fs);
    int unsigned w;
    int unsigned h;
    int unsigned vsum;
    int unsigned hsum;
    smoothed_t   res;
    w = clamp_size(width_reg, MAX_COLS);
    h = clamp_size(height_reg, MAX_ROWS);
    if (fs) begin
      row_cnt = '0;
      col_cnt = '0;
    end
    vsum = pix;
    for (int k = bf7_pkg::LINES - 1; k >= 0; k--) begin
      vsum += column_lines[k][col_cnt];
      if (k > 0) column_lines[k][col_cnt] = column_lines[k-1][col_cnt];
    end
    column_lines[0][col_cnt] = pix;
    hsum = vsum;
    for (int k = bf7_pkg::TAPS - 1; k > 0; k--) begin
      col_sums[k] = col_sums[k-1];
      hsum += col_sums[k];
    end
    col_sums[0] = bf7_pkg::VSUM_W'(vsum);
    if (row_cnt >= bf7_pkg::TAPS - 1 && col_cnt >= bf7_pkg::TAPS - 1) begin
      res.row   = bf7_pkg::COORD_W'(row_cnt - bf7_pkg::HALF);
      res.col   = bf7_pkg::COORD_W'(col_cnt - bf7_pkg::HALF);
      res.value = pin_active ? pin_value : bf7_pkg::PIX_W'(hsum / WINDOW_AREA);
      smoothed_due.push_back(res);
    end
    if (col_cnt >= w - 1) begin
      col_cnt = '0;
      if (row_cnt >= h - 1) row_cnt = '0;
      else row_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers (entered and left at a falling edge)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [bf7_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bf7_pkg::REG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == bf7_pkg::CFG_IMAGE_WIDTH) width_reg = val;
    else if (idx == bf7_pkg::CFG_IMAGE_HEIGHT) height_reg = val;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic push_pixel(input logic [bf7_pkg::PIX_W-1:0] pix, input logic fs);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    smooth_pixel(pix, fs);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Wait for every expected word, then let pixels that emit nothing drain.
  task automatic settle();
    while (smoothed_due.size() != 0) @(negedge clk_i);
    repeat (PIPE_SLACK) @(negedge clk_i);
  endtask

  function automatic logic [bf7_pkg::PIX_W-1:0] fill_pixel(input fill_e f, input int r,
                                                           input int c);
    case (f)
      FILL_ZERO:    return '0;
      FILL_FULL:    return '1;
      FILL_RAMP:    return bf7_pkg::PIX_W'(r * 16 + c * 3);
      FILL_CHECKER: return ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
      default:      return bf7_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output_req) begin
        hold_output_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Output check against the oldest expected word.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_word.row   = m_axis_tdata[bf7_pkg::COORD_W-1:0];
      got_word.col   = m_axis_tdata[2*bf7_pkg::COORD_W-1:bf7_pkg::COORD_W];
      got_word.value = m_axis_tdata[2*bf7_pkg::COORD_W +: bf7_pkg::PIX_W];
      words_checked++;
      if (smoothed_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word row %0d col %0d value %0d",
                   got_word.row, got_word.col, got_word.value);
      end else begin
        want_word = smoothed_due.pop_front();
        if (got_word.row !== want_word.row || got_word.col !== want_word.col ||
            got_word.value !== want_word.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected row %0d col %0d value %0d, got row %0d col %0d value %0d",
                     want_word.row, want_word.col, want_word.value,
                     got_word.row, got_word.col, got_word.value);
        end
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("ERROR: timeout with %0d words still expected", smoothed_due.size());
    $display("box_filter_7x7_separable_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    frame_case_t               frame_cases [8];
    frame_case_t               fc;
    int unsigned               w;
    int unsigned               h;
    int unsigned               n;
    int unsigned               d;
    int unsigned               cur_w;
    int unsigned               random_pixels;
    logic [bf7_pkg::REG_W-1:0] nw;
    logic [bf7_pkg::REG_W-1:0] nh;
    bit                        mark_first;
    bit                        noisy;
    bit                        extreme;
    logic                      fs;

    // reset geometry first (one full row that must not wrap early), then
    // clamping at both ends and frame wrap without a marker
    frame_cases = '{
      '{KEEP, KEEP,   1, FILL_FULL,    1'b0, 1'b0, 8'd0,   1'b0},
      '{0,    0,      7, FILL_ZERO,    1'b1, 1'b1, 8'd0,   1'b1},
      '{7,    7,      7, FILL_FULL,    1'b1, 1'b1, 8'd255, 1'b0},
      '{9,    8,      8, FILL_RAMP,    1'b1, 1'b0, 8'd0,   1'b0},
      '{10,   7,     14, FILL_CHECKER, 1'b1, 1'b0, 8'd0,   1'b0},
      '{12,   1,      7, FILL_RANDOM,  1'b1, 1'b0, 8'd0,   1'b1},
      '{3,    1023,   9, FILL_RANDOM,  1'b1, 1'b0, 8'd0,   1'b0},
      '{11,   10,    10, FILL_RANDOM,  1'b1, 1'b0, 8'd0,   1'b0}
    };

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;

    foreach (column_lines[i, j]) column_lines[i][j] = '0;
    foreach (col_sums[i]) col_sums[i] = '0;
    row_cnt    = '0;
    col_cnt    = '0;
    width_reg  = bf7_pkg::REG_RESET;
    height_reg = bf7_pkg::REG_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames
    foreach (frame_cases[i]) begin
      fc = frame_cases[i];
      settle();
      if (fc.cfg_w != KEEP) write_reg(bf7_pkg::CFG_IMAGE_WIDTH, bf7_pkg::REG_W'(fc.cfg_w));
      if (fc.cfg_h != KEEP) write_reg(bf7_pkg::CFG_IMAGE_HEIGHT, bf7_pkg::REG_W'(fc.cfg_h));
      if (fc.spare) begin
        write_reg(CFG_SPARE_2, bf7_pkg::REG_W'($urandom));
        write_reg(CFG_SPARE_3, bf7_pkg::REG_W'($urandom));
      end
      cfg_valid_i <= 1'b0;
      pin_active = fc.pinned;
      pin_value  = fc.pin_value;
      w = clamp_size(width_reg, MAX_COLS);
      for (int r = 0; r < fc.rows; r++)
        for (int c = 0; c < w; c++)
          push_pixel(fill_pixel(fc.fill, r, c), fc.mark && r == 0 && c == 0);
      s_axis_tvalid <= 1'b0;
      pin_active = 1'b0;
    end

    // random bursts: mostly whole frames, some cut short with stray markers
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      random_bursts++;
      steady = (random_bursts >= 2 && random_bursts < 4);
      settle();
      cur_w = clamp_size(width_reg, MAX_COLS);
      mark_first = 1'b0;
      d = $urandom_range(99);
      if (d < 65) begin
        // new geometry, new frame
        d = $urandom_range(99);
        if (d < 85) nw = bf7_pkg::REG_W'($urandom_range(16, 7));
        else if (d < 95) nw = bf7_pkg::REG_W'($urandom_range(6, 0));
        else nw = bf7_pkg::REG_W'($urandom_range(40, 17));
        d = $urandom_range(99);
        if (d < 85) nh = bf7_pkg::REG_W'($urandom_range(12, 7));
        else if (d < 95) nh = bf7_pkg::REG_W'($urandom_range(6, 0));
        else nh = bf7_pkg::REG_W'($urandom_range(20, 13));
        if ($urandom_range(9) != 0) write_reg(bf7_pkg::CFG_IMAGE_WIDTH, nw);
        if ($urandom_range(9) != 0) write_reg(bf7_pkg::CFG_IMAGE_HEIGHT, nh);
        if ($urandom_range(3) == 0)
          write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, bf7_pkg::REG_W'($urandom));
        mark_first = 1'b1;
      end else if (d < 85) begin
        // shrink mid-frame: counters may sit past the new row end
        write_reg(bf7_pkg::CFG_IMAGE_WIDTH, bf7_pkg::REG_W'($urandom_range(cur_w, 5)));
        if ($urandom_range(1) != 0)
          write_reg(bf7_pkg::CFG_IMAGE_HEIGHT, bf7_pkg::REG_W'($urandom_range(14, 0)));
      end
      cfg_valid_i <= 1'b0;

      w = clamp_size(width_reg, MAX_COLS);
      h = clamp_size(height_reg, MAX_ROWS);
      noisy = ($urandom_range(99) >= 75);
      if (random_bursts == 1) begin
        hold_output_req = 1'b1;   // keep sending while the receiver sits
        noisy = 1'b0;             // a whole frame, so words back up
      end
      if (noisy) n = $urandom_range(w * h, 1);
      else n = w * h * $urandom_range(2, 1);
      extreme = ($urandom_range(99) < 15);
      for (int unsigned k = 0; k < n; k++) begin
        fs = (k == 0 && mark_first) || (noisy && $urandom_range(99) < 3);
        push_pixel(extreme ? ($urandom_range(1) ? 8'hFF : 8'h00)
                           : bf7_pkg::PIX_W'($urandom), fs);
        random_pixels++;
      end
      s_axis_tvalid <= 1'b0;
    end

    steady = 1'b0;
    settle();

    $display("Sent %0d pixels: %0d directed frames, %0d random bursts, %0d reg writes.",
             pixels_sent, $size(frame_cases), random_bursts, cfg_writes);
    $display("Compared %0d words (%0d bad), clamped sizes, one %0d-cycle output stall.",
             words_checked, mismatches, HOLD_CYCLES);
    if (mismatches == 0 && smoothed_due.size() == 0) begin
      $display("box_filter_7x7_separable_top test passed");
    end else begin
      $display("box_filter_7x7_separable_top test failed");
    end
    $finish;
  end

endmodule
